[rtl/qamd_pkg.sv]
// Shared widths, defaults and mode codes for the QAM hard-decision demapper.
`default_nettype none

package qamd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 12;

    localparam int GAIN_WIDTH   = 16;
    localparam int AXIS_WIDTH   = 2;
    localparam int LABEL_WIDTH  = 4;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd6476;

    typedef enum logic [1:0] {
        MOD_BPSK  = 2'd0,
        MOD_QPSK  = 2'd1,
        MOD_QAM16 = 2'd2,
        MOD_RSVD  = 2'd3
    } mod_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_MODULATION = 2'd0,
        REG_GRAY_CODED = 2'd1,
        REG_SCALE_GAIN = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/qamd_axis_slice.sv]
// Turns a scaled 16QAM product into a column or row index 0..3.
`default_nettype none

module qamd_axis_slice
    import qamd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int PROD_WIDTH   = SAMPLE_WIDTH + GAIN_WIDTH + 1
)
(
    input  wire logic signed [PROD_WIDTH-1:0] product,
    output      logic [AXIS_WIDTH-1:0]        index
);

    localparam logic signed [PROD_WIDTH-1:0] SAT_HI =
        {{(PROD_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [PROD_WIDTH-1:0] SAT_LO =
        {{(PROD_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH+1:0] OFFSET = (SAMPLE_WIDTH+2)'(2);
    localparam logic signed [SAMPLE_WIDTH+1:0] TOP    = (SAMPLE_WIDTH+2)'(3);

    logic signed [PROD_WIDTH-1:0]   shifted;
    logic signed [SAMPLE_WIDTH-1:0] sat;
    logic signed [SAMPLE_WIDTH-1:0] whole;
    logic signed [SAMPLE_WIDTH+1:0] biased;

    always_comb
    begin
        // floor division by 2^F, then clamp to the sample range
        shifted = product >>> FRAC_BITS;
        if (shifted > SAT_HI)
        begin
            sat = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            sat = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sat = shifted[SAMPLE_WIDTH-1:0];
        end

        // adding 2.0 then taking the integer part == integer part plus 2
        whole  = sat >>> FRAC_BITS;
        biased = {{2{whole[SAMPLE_WIDTH-1]}}, whole} + OFFSET;

        if (biased < 0)
        begin
            index = '0;
        end
        else if (biased > TOP)
        begin
            index = TOP[AXIS_WIDTH-1:0];
        end
        else
        begin
            index = biased[AXIS_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/qam_hard_decision_demapper.sv]
// Throughput: one sample per clock while the sink keeps out_ready high.
// Three register stages (sample, gain product, label) lie between the input transfer and out.
// The gain multiplier sits alone between the sample and product registers.
// Each stage advances when the stage after it is empty or moving, so stalls back up.
// Reset: pipeline empties; modulation = BPSK, gray_coded = 1, scale_gain = 6476.
`default_nettype none

module qam_hard_decision_demapper
    import qamd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0]       cfg_index,
    input  wire logic [GAIN_WIDTH-1:0]          cfg_data,

    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] in_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] in_imag,

    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic [LABEL_WIDTH-1:0]         symbol_bits
);

    localparam int PROD_WIDTH = SAMPLE_WIDTH + GAIN_WIDTH + 1;

    // configuration
    mod_t                  modulation_reg;
    logic                  gray_coded_reg;
    logic [GAIN_WIDTH-1:0] scale_gain_reg;

    // stage 1: sample
    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_real_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_imag_reg;

    // stage 2: products and signs
    logic                         s2_valid_reg;
    logic signed [PROD_WIDTH-1:0] s2_prod_re_reg;
    logic signed [PROD_WIDTH-1:0] s2_prod_im_reg;
    logic                         s2_re_neg_reg;
    logic                         s2_im_neg_reg;
    logic signed [PROD_WIDTH-1:0] prod_re_next;
    logic signed [PROD_WIDTH-1:0] prod_im_next;

    // stage 3: label
    logic                   out_valid_reg;
    logic [LABEL_WIDTH-1:0] label_reg;
    logic [LABEL_WIDTH-1:0] label_next;

    logic                  out_adv;
    logic                  s2_adv;
    logic                  s1_adv;
    logic                  in_xfer;
    logic [AXIS_WIDTH-1:0] col;
    logic [AXIS_WIDTH-1:0] row;
    logic [AXIS_WIDTH-1:0] row_snake;
    logic [LABEL_WIDTH-1:0] lin;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_reg <= MOD_BPSK;
            gray_coded_reg <= 1'b1;
            scale_gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODULATION: modulation_reg <= mod_t'(cfg_data[1:0]);
                REG_GRAY_CODED: gray_coded_reg <= cfg_data[0];
                REG_SCALE_GAIN: scale_gain_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // stall chain from the output back to the input
    assign out_adv  = !out_valid_reg || out_ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign prod_re_next = s1_real_reg * $signed({1'b0, scale_gain_reg});
    assign prod_im_next = s1_imag_reg * $signed({1'b0, scale_gain_reg});

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_real_reg <= in_real;
            s1_imag_reg <= in_imag;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_prod_re_reg <= prod_re_next;
            s2_prod_im_reg <= prod_im_next;
            s2_re_neg_reg  <= s1_real_reg[SAMPLE_WIDTH-1];
            s2_im_neg_reg  <= s1_imag_reg[SAMPLE_WIDTH-1];
        end
        if (out_adv && s2_valid_reg)
        begin
            label_reg <= label_next;
        end
    end

    qamd_axis_slice #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .PROD_WIDTH   (PROD_WIDTH)
    ) u_col (
        .product (s2_prod_re_reg),
        .index   (col)
    );

    qamd_axis_slice #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .PROD_WIDTH   (PROD_WIDTH)
    ) u_row (
        .product (s2_prod_im_reg),
        .index   (row)
    );

    // snake order: rows run downward in even columns
    assign row_snake = col[0] ? row : ~row;
    assign lin       = {col, row_snake};

    always_comb
    begin
        case (modulation_reg)
            MOD_BPSK:
            begin
                label_next = {3'b000, s2_re_neg_reg};
            end
            MOD_QPSK:
            begin
                if (!s2_im_neg_reg)
                begin
                    label_next = {3'b000, s2_re_neg_reg};
                end
                else
                begin
                    label_next = {3'b001, s2_re_neg_reg ^ !gray_coded_reg};
                end
            end
            MOD_QAM16:
            begin
                label_next = gray_coded_reg ? (lin ^ (lin >> 1)) : lin;
            end
            default:
            begin
                label_next = '0;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign symbol_bits = label_reg;

endmodule

`default_nettype wire

[verif/qam_hard_decision_demapper_test.sv]
// Self-checking testbench for the BPSK/QPSK/16QAM hard-decision demapper.
`default_nettype none

module qam_hard_decision_demapper_test
    import qamd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int FB          = FRAC_BITS_DEF;
    localparam int PIPE_SLACK  = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 75;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [GAIN_WIDTH-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [SW-1:0]     in_real = '0;
    logic signed [SW-1:0]     in_imag = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [LABEL_WIDTH-1:0]   symbol_bits;

    // Shadow copy of the block's registers
    mod_t                     cur_mod = MOD_BPSK;
    logic                     cur_gray = 1'b1;
    logic [GAIN_WIDTH-1:0]    cur_gain = GAIN_RESET;

    logic [LABEL_WIDTH-1:0]   pending_labels[$];
    int                       fail_count = 0;
    int                       cycle_count = 0;
    bit                       sender_steady = 1'b0;
    bit                       sink_steady = 1'b0;
    int                       sink_stall_left = 0;

    qam_hard_decision_demapper dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_real    (in_real),
        .in_imag    (in_imag),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .symbol_bits(symbol_bits)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Column or row index of one 16QAM axis: scale, floor, saturate, add 2.0, clamp
    function automatic logic [AXIS_WIDTH-1:0] axis_level(logic signed [SW-1:0] s,
                                                         logic [GAIN_WIDTH-1:0] gain);
        longint prod;
        longint q;
        longint v;
        longint hi;
        prod = longint'(s) * longint'(gain);
        q = prod >>> FB;
        hi = (longint'(1) <<< (SW - 1)) - 1;
        if (q > hi)
            q = hi;
        if (q < -hi - 1)
            q = -hi - 1;
        v = q + (longint'(2) <<< FB);
        if (v < 0)
            return '0;
        v = v >>> FB;
        if (v > 3)
            return 2'd3;
        return v[AXIS_WIDTH-1:0];
    endfunction

    function automatic logic [LABEL_WIDTH-1:0] predict_label(logic signed [SW-1:0] re,
                                                             logic signed [SW-1:0] im);
        logic [AXIS_WIDTH-1:0]  col;
        logic [AXIS_WIDTH-1:0]  row;
        logic [LABEL_WIDTH-1:0] snake;
        case (cur_mod)
            MOD_BPSK:
                return (re < 0) ? 4'd1 : 4'd0;
            MOD_QPSK:
            begin
                if (im >= 0)
                    return (re < 0) ? 4'd1 : 4'd0;
                else if (re >= 0)
                    return cur_gray ? 4'd2 : 4'd3;
                else
                    return cur_gray ? 4'd3 : 4'd2;
            end
            MOD_QAM16:
            begin
                col = axis_level(re, cur_gain);
                row = axis_level(im, cur_gain);
                // rows run backward in even columns
                snake = {col, col[0] ? row : 2'd3 - row};
                return cur_gray ? (snake ^ (snake >> 1)) : snake;
            end
            default:
                return '0;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return SW'($urandom());
        else if (roll < 70)
            return SW'($urandom_range(0, 8191) - 4096);
        else if (roll < 90)
            return SW'($urandom_range(0, 32767) - 16384);
        case ($urandom_range(0, 3))
            0: return -SW'(32768);
            1: return -SW'(1);
            2: return '0;
            default: return SW'(32767);
        endcase
    endfunction

    function automatic logic [GAIN_WIDTH-1:0] random_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return GAIN_RESET;
            3: return 16'd4096;
            default: return GAIN_WIDTH'($urandom());
        endcase
    endfunction

    // Sink side: random back-pressure, with steady stretches
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            sink_steady = !sink_steady;
        if (sink_stall_left > 0)
        begin
            sink_stall_left--;
            out_ready <= 1'b0;
        end
        else if (!sink_steady && rst_n && $urandom_range(0, 99) < 30)
        begin
            sink_stall_left = pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_labels.size() == 0)
            begin
                $error("symbol_bits: unexpected result, actual %0d", symbol_bits);
                fail_count++;
            end
            else
            begin
                logic [LABEL_WIDTH-1:0] want;
                want = pending_labels.pop_front();
                if (symbol_bits !== want)
                begin
                    $error("symbol_bits: expected %0d, actual %0d", want, symbol_bits);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_real  <= re;
        in_imag  <= im;
        do @(posedge clk); while (!in_ready);
        pending_labels = {pending_labels, predict_label(re, im)};
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_labels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_WIDTH-1:0] value);
        hold_until_drained();
        repeat (PIPE_SLACK) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODULATION: cur_mod  = mod_t'(value[1:0]);
            REG_GRAY_CODED: cur_gray = value[0];
            REG_SCALE_GAIN: cur_gain = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        // BPSK with reset settings, sign boundary
        send_sample('0, '0);
        send_sample(-SW'(1), SW'(32767));
        send_sample(-SW'(32768), -SW'(32768));
    endtask

    task automatic test_qpsk_quadrants();
        write_reg(REG_MODULATION, GAIN_WIDTH'(MOD_QPSK));
        send_sample('0, '0);
        send_sample(-SW'(1), '0);
        send_sample('0, -SW'(1));
        send_sample(-SW'(32768), -SW'(32768));
        write_reg(REG_GRAY_CODED, 16'd0);
        send_sample(SW'(32767), -SW'(1));
        send_sample(-SW'(1), -SW'(32768));
    endtask

    task automatic test_qam16_corners();
        // binary labels still in force, then Gray
        write_reg(REG_MODULATION, GAIN_WIDTH'(MOD_QAM16));
        send_sample(SW'(32767), SW'(32767));
        send_sample(-SW'(32768), -SW'(32768));
        write_reg(REG_GRAY_CODED, 16'd1);
        send_sample('0, '0);
        send_sample(SW'(2590), -SW'(2590));
        write_reg(REG_SCALE_GAIN, 16'd4096);
        send_sample(-SW'(8193), -SW'(8192));
        send_sample(SW'(4095), SW'(4096));
        // floor rounding: -1 * tiny gain lands just under zero
        write_reg(REG_SCALE_GAIN, 16'd1);
        send_sample(-SW'(1), SW'(1));
        write_reg(REG_SCALE_GAIN, 16'hFFFF);
        send_sample(SW'(32767), -SW'(32768));
        send_sample(SW'(1), -SW'(1));
    endtask

    task automatic test_register_edge_cases();
        write_reg(REG_SCALE_GAIN, 16'd0);
        send_sample(SW'(32767), -SW'(32768));
        // index with no register behind it must change nothing
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(-SW'(32768), SW'(32767));
        // upper data bits are dropped on narrow registers
        write_reg(REG_MODULATION, 16'hFFFD);
        write_reg(REG_GRAY_CODED, 16'hFFFE);
        send_sample(-SW'(1), -SW'(1));
        write_reg(REG_MODULATION, GAIN_WIDTH'(MOD_RSVD));
        send_sample(-SW'(32768), -SW'(1));
        send_sample(SW'(5), SW'(7));
    endtask

    task automatic test_random_traffic();
        mod_t phase_mods[8];
        phase_mods = '{MOD_QAM16, MOD_QPSK, MOD_BPSK, MOD_QAM16,
                       MOD_RSVD, MOD_QAM16, MOD_QPSK, MOD_QAM16};
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_MODULATION,
                      {(GAIN_WIDTH-2)'($urandom_range(0, 16383)), phase_mods[phase]});
            write_reg(REG_GRAY_CODED,
                      {(GAIN_WIDTH-1)'($urandom_range(0, 32767)), phase[0]});
            write_reg(REG_SCALE_GAIN, (phase == 0) ? GAIN_RESET : random_gain());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, GAIN_WIDTH'($urandom()));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 25 == 0)
                    sender_steady = ($urandom_range(0, 2) == 0);
                if (n == PHASE_ITEMS / 2)
                    hold_until_drained();
                send_sample(random_sample(), random_sample());
            end
        end
        sender_steady = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_qpsk_quadrants();
        test_qam16_corners();
        test_register_edge_cases();
        test_random_traffic();
        hold_until_drained();
        repeat (PIPE_SLACK * 2) @(posedge clk);
        if (fail_count == 0 && pending_labels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
